// ===== hdl/msa_pkg.sv =====
// Shared types and constants for the Mandelbrot stripe-average block.
`default_nettype none
package msa_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int AVG_WIDTH_DEF   = 16;
	localparam int ITER_WIDTH      = 10;
	localparam int BAIL_WIDTH      = 6;
	localparam int APB_ADDR_WIDTH  = 3;
	localparam int APB_DATA_WIDTH  = 32;

	localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 10'd500;
	localparam logic [BAIL_WIDTH-1:0] BAILOUT_RESET  = 6'd63;

	// register index = paddr[2]
	localparam logic REG_MAX_ITER = 1'b0;
	localparam logic REG_BAILOUT  = 1'b1;

	// divide / square-root unit operations
	localparam logic MODE_DIV  = 1'b0;
	localparam logic MODE_SQRT = 1'b1;

	typedef struct packed {
		logic start;
		logic mode;
	} dsu_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/msa_mul.sv =====
// Registered signed multiplier shared by all orbit products.
`default_nettype none
module msa_mul #(
	parameter int W = msa_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic signed [W-1:0]   a,
	input  wire logic signed [W-1:0]   b,
	output logic signed [2*W-1:0]      p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
`default_nettype wire

// ===== hdl/msa_dsu.sv =====
// Shared bit-serial unit: restoring division and digit-by-digit square root.
`default_nettype none
module msa_dsu import msa_pkg::*; #(
	parameter int XW = 64,
	parameter int QW = 32,
	parameter int DW = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dsu_ctl_t                     ctl,
	input  wire logic [XW-1:0]                x,
	input  wire logic [DW-1:0]                d,
	input  wire logic [$clog2(XW+1)-1:0]      steps,
	output logic [QW-1:0]                     q_q,
	output logic                              done_q
);

	localparam int RW = QW + 3;
	localparam int SW = $clog2(XW+1);

	logic [XW-1:0] x_q;
	logic [RW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic          mode_q;
	logic [SW-1:0] cnt_q;
	logic          busy_q;

	logic [RW-1:0] rs;
	logic [RW-1:0] trial;
	logic          ge;

	always_comb begin
		if (mode_q == MODE_SQRT) begin
			rs    = {r_q[RW-3:0], x_q[XW-1:XW-2]};
			trial = RW'({q_q, 2'b01});
		end else begin
			rs    = {r_q[RW-2:0], x_q[XW-1]};
			trial = RW'(d_q);
		end
		ge = (rs >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - SW'(1);
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q    <= x;
			r_q    <= '0;
			q_q    <= '0;
			d_q    <= d;
			mode_q <= ctl.mode;
		end else if (busy_q) begin
			// consume one quotient or root digit
			x_q <= (mode_q == MODE_SQRT) ? (x_q << 2) : (x_q << 1);
			r_q <= ge ? (rs - trial) : rs;
			q_q <= {q_q[QW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mandelbrot_stripe_average.sv =====
// Top level: orbit sequencer, configuration registers and result register.
//
//  channel  | direction | handshake          | payload
//  input    | in        | in_valid/in_ready  | c_re, c_im
//  result   | out       | out_valid/out_ready| escaped, iter_count, stripe_avg
//  config   | in        | APB psel/penable   | iter_limit @0, bailout_sq @4
//
// One point at a time. Each iteration runs the bit-serial square root and
// the term division on the shared divide/sqrt unit; the final mean is one
// more division on that unit.
// in_ready is high only while idle; a finished result waits in the output
// register while the next point is accepted and iterated.
// Reset loads iter_limit 500 and bailout_sq 63 and clears all control state.
`default_nettype none
module mandelbrot_stripe_average import msa_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int AVG_WIDTH   = AVG_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] c_re,
	input  wire logic signed [COORD_WIDTH-1:0] c_im,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               escaped,
	output logic [ITER_WIDTH-1:0]              iter_count,
	output logic [AVG_WIDTH-1:0]               stripe_avg,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [APB_ADDR_WIDTH-1:0]     paddr,
	input  wire logic [APB_DATA_WIDTH-1:0]     pwdata,
	output logic [APB_DATA_WIDTH-1:0]          prdata,
	output logic                               pready
);

	localparam int W    = COORD_WIDTH;
	localparam int A    = AVG_WIDTH;
	localparam int F    = W - 4;
	localparam int PW   = 2 * W;
	localparam int NW   = W + A - 1;
	localparam int SUMW = A + ITER_WIDTH;
	localparam int QW   = (W > A) ? W : A;
	localparam int XW0  = (PW > NW) ? PW : NW;
	localparam int XW   = (XW0 > SUMW) ? XW0 : SUMW;
	localparam int SW   = $clog2(XW + 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CHECK   = 4'd1;
	localparam logic [3:0] S_MRI     = 4'd2;
	localparam logic [3:0] S_NEW     = 4'd3;
	localparam logic [3:0] S_SQR     = 4'd4;
	localparam logic [3:0] S_SQI     = 4'd5;
	localparam logic [3:0] S_MAG     = 4'd6;
	localparam logic [3:0] S_SUMSQ   = 4'd7;
	localparam logic [3:0] S_SQRT_GO = 4'd8;
	localparam logic [3:0] S_SQRT    = 4'd9;
	localparam logic [3:0] S_DIV_GO  = 4'd10;
	localparam logic [3:0] S_DIV     = 4'd11;
	localparam logic [3:0] S_AVG_GO  = 4'd12;
	localparam logic [3:0] S_AVG     = 4'd13;
	localparam logic [3:0] S_FIN     = 4'd14;

	logic [3:0] state_q;

	logic [ITER_WIDTH-1:0] max_iter_q;
	logic [BAIL_WIDTH-1:0] bailout_q;

	logic signed [W-1:0] cr_q, ci_q, zr_q, zi_q;
	logic [PW-1:0]       sqr_q, sqi_q, magsq_q, diff_q, pri_q;
	logic                ovf_q;
	logic [SUMW-1:0]     sum_q;
	logic [ITER_WIDTH-1:0] i_q;
	logic [W-1:0]        mag_q;
	logic                esc_q;
	logic [A-1:0]        avg_q;

	logic                  out_valid_q;
	logic                  escaped_q;
	logic [ITER_WIDTH-1:0] iter_q;
	logic [A-1:0]          avg_out_q;

	logic signed [W-1:0]  mul_a, mul_b;
	logic signed [PW-1:0] mul_p;

	dsu_ctl_t      dsu_ctl;
	logic [XW-1:0] dsu_x;
	logic [W-1:0]  dsu_d;
	logic [SW-1:0] dsu_steps;
	logic [QW-1:0] dsu_q;
	logic          dsu_done;

	logic [PW-1:0]  limit;
	logic [W+4:0]   nr_sum;
	logic [W+5:0]   ni_sum;
	logic [W-1:0]   nr_sat, ni_sat;
	logic           nr_ovf, ni_ovf;
	logic [W-1:0]   aim;
	logic [NW-1:0]  term_num;
	logic           load_out;
	logic           cfg_wr;

	localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
			bailout_q  <= BAILOUT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_ITER: max_iter_q <= pwdata[ITER_WIDTH-1:0];
				REG_BAILOUT:  bailout_q  <= pwdata[BAIL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_ITER: prdata = APB_DATA_WIDTH'(max_iter_q);
			REG_BAILOUT:  prdata = APB_DATA_WIDTH'(bailout_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------- shared units ----------------
	assign mul_a = (state_q == S_SQI) ? zi_q : zr_q;
	assign mul_b = (state_q == S_SQR) ? zr_q : zi_q;

	msa_mul #(.W(W)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	assign aim      = zi_q[W-1] ? (~zi_q + W'(1)) : zi_q;
	assign term_num = NW'(aim) << (A - 1);

	always_comb begin
		dsu_ctl.start = 1'b0;
		dsu_ctl.mode  = MODE_DIV;
		dsu_x         = XW'(term_num) << (XW - NW);
		dsu_d         = mag_q;
		dsu_steps     = SW'(NW);
		case (state_q)
			S_SQRT_GO: begin
				dsu_ctl.start = 1'b1;
				dsu_ctl.mode  = MODE_SQRT;
				dsu_x         = XW'(magsq_q) << (XW - PW);
				dsu_steps     = SW'(W);
			end
			S_DIV_GO: begin
				dsu_ctl.start = 1'b1;
			end
			S_AVG_GO: begin
				dsu_ctl.start = 1'b1;
				dsu_x         = XW'(sum_q) << (XW - SUMW);
				dsu_d         = W'(i_q);
				dsu_steps     = SW'(SUMW);
			end
			default: ;
		endcase
	end

	msa_dsu #(.XW(XW), .QW(QW), .DW(W)) u_dsu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dsu_ctl),
		.x      (dsu_x),
		.d      (dsu_d),
		.steps  (dsu_steps),
		.q_q    (dsu_q),
		.done_q (dsu_done)
	);

	// ---------------- orbit update ----------------
	assign limit = PW'(bailout_q) << (2 * F);

	// floor shift then add c; saturate to the coordinate range
	assign nr_sum = {diff_q[PW-1], diff_q[PW-1:F]} + {{5{cr_q[W-1]}}, cr_q};
	assign ni_sum = {pri_q[PW-1], pri_q[PW-1:F-1]} + {{6{ci_q[W-1]}}, ci_q};

	always_comb begin
		nr_ovf = (nr_sum[W+4:W-1] != {6{nr_sum[W+4]}});
		ni_ovf = (ni_sum[W+5:W-1] != {7{ni_sum[W+5]}});
		nr_sat = nr_ovf ? (nr_sum[W+4] ? SAT_MIN : SAT_MAX) : nr_sum[W-1:0];
		ni_sat = ni_ovf ? (ni_sum[W+5] ? SAT_MIN : SAT_MAX) : ni_sum[W-1:0];
	end

	assign in_ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:    if (in_valid) state_q <= S_CHECK;
				S_CHECK: begin
					if (i_q == max_iter_q) state_q <= S_FIN;
					else if (ovf_q || magsq_q > limit)
						state_q <= (i_q == '0) ? S_FIN : S_AVG_GO;
					else state_q <= S_MRI;
				end
				S_MRI:     state_q <= S_NEW;
				S_NEW:     state_q <= S_SQR;
				S_SQR:     state_q <= S_SQI;
				S_SQI:     state_q <= S_MAG;
				S_MAG:     state_q <= S_SUMSQ;
				S_SUMSQ:   state_q <= S_SQRT_GO;
				S_SQRT_GO: state_q <= S_SQRT;
				S_SQRT: begin
					if (dsu_done) state_q <= (dsu_q[W-1:0] == '0) ? S_CHECK : S_DIV_GO;
				end
				S_DIV_GO:  state_q <= S_DIV;
				S_DIV:     if (dsu_done) state_q <= S_CHECK;
				S_AVG_GO:  state_q <= S_AVG;
				S_AVG:     if (dsu_done) state_q <= S_FIN;
				S_FIN:     if (load_out) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cr_q    <= c_re;
				ci_q    <= c_im;
				zr_q    <= '0;
				zi_q    <= '0;
				sqr_q   <= '0;
				sqi_q   <= '0;
				magsq_q <= '0;
				ovf_q   <= 1'b0;
				sum_q   <= '0;
				i_q     <= '0;
			end
			S_CHECK: begin
				avg_q <= '0;
				esc_q <= (i_q != max_iter_q);
			end
			S_MRI: begin
				pri_q  <= mul_p;
				diff_q <= sqr_q - sqi_q;
			end
			S_NEW: begin
				zr_q  <= nr_sat;
				zi_q  <= ni_sat;
				ovf_q <= ovf_q | nr_ovf | ni_ovf;
			end
			S_SQI:   sqr_q   <= mul_p;
			S_MAG:   sqi_q   <= mul_p;
			S_SUMSQ: magsq_q <= sqr_q + sqi_q;
			S_SQRT: begin
				if (dsu_done) begin
					mag_q <= dsu_q[W-1:0];
					// zero magnitude adds no term
					if (dsu_q[W-1:0] == '0) i_q <= i_q + ITER_WIDTH'(1);
				end
			end
			S_DIV: begin
				if (dsu_done) begin
					sum_q <= sum_q + SUMW'(dsu_q[A-1:0]);
					i_q   <= i_q + ITER_WIDTH'(1);
				end
			end
			S_AVG:   if (dsu_done) avg_q <= dsu_q[A-1:0];
			default: ;
		endcase
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			escaped_q <= esc_q;
			iter_q    <= i_q;
			avg_out_q <= avg_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign escaped    = escaped_q;
	assign iter_count = iter_q;
	assign stripe_avg = avg_out_q;

endmodule
`default_nettype wire

// ===== hdl/msa_chk.sv =====
// Port-level checker for the stripe-average block, bound to the top level.
`default_nettype none
module msa_chk import msa_pkg::*; #(
	parameter int AVG_WIDTH   = AVG_WIDTH_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          escaped,
	input wire logic [ITER_WIDTH-1:0]         iter_count,
	input wire logic [AVG_WIDTH-1:0]          stripe_avg,
	input wire logic                          pready
);

	// a held result keeps its value until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(escaped)
			&& $stable(iter_count) && $stable(stripe_avg))
		else $error("result changed while stalled");

	a_no_esc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !escaped |-> stripe_avg == '0)
		else $error("nonzero average without escape");

	a_esc_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escaped |-> iter_count != '0)
		else $error("escape reported at index zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after transaction");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind mandelbrot_stripe_average msa_chk #(
	.AVG_WIDTH  (AVG_WIDTH)
) u_msa_chk (.*);
`default_nettype wire

// ===== verif/mandelbrot_stripe_average_tb.sv =====
// Self-checking testbench for the Mandelbrot stripe-average block.
`default_nettype none
module mandelbrot_stripe_average_tb import msa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int AW = AVG_WIDTH_DEF;
	localparam int FRAC = CW - 4;
	localparam logic [APB_ADDR_WIDTH-1:0] ADDR_MAX_ITER = {REG_MAX_ITER, 2'b00};
	localparam logic [APB_ADDR_WIDTH-1:0] ADDR_BAILOUT  = {REG_BAILOUT, 2'b00};
	localparam int ONE = 1 << FRAC;

	typedef struct {
		logic            escaped;
		logic [ITER_WIDTH-1:0] iter_count;
		logic [AW-1:0]   stripe_avg;
	} stripe_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] c_re = '0;
	logic signed [CW-1:0] c_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic escaped;
	logic [ITER_WIDTH-1:0] iter_count;
	logic [AW-1:0] stripe_avg;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_WIDTH-1:0] paddr = '0;
	logic [APB_DATA_WIDTH-1:0] pwdata = '0;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic pready;

	logic [ITER_WIDTH-1:0] limit_setting = MAX_ITER_RESET;
	logic [BAIL_WIDTH-1:0] bailout_setting = BAILOUT_RESET;
	stripe_result_t pending_results[$];
	int error_count = 0;
	int points_sent = 0;
	int results_seen = 0;
	int escapes_seen = 0;
	bit quiet = 1'b0;
	int hold_left = 0;

	mandelbrot_stripe_average dut (
		.clk, .arst_n, .in_valid, .in_ready, .c_re, .c_im,
		.out_valid, .out_ready, .escaped, .iter_count, .stripe_avg,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp_coord(longint v, ref bit ovf);
		longint hi = (longint'(1) << (CW - 1)) - 1;
		longint lo = -hi - 1;
		if (v > hi) begin
			ovf = 1'b1;
			return hi;
		end
		if (v < lo) begin
			ovf = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic stripe_result_t predict_point(logic signed [CW-1:0] re,
			logic signed [CW-1:0] im);
		stripe_result_t r;
		longint cr = re;
		longint ci = im;
		longint zr = 0;
		longint zi = 0;
		longint nr, ni;
		bit ovf = 1'b0;
		longint unsigned total = 0;
		longint unsigned limit_sq = longint'(bailout_setting) << (2 * FRAC);
		longint unsigned mag, aim, msq;
		for (int i = 0; i < limit_setting; i++) begin
			msq = longint'(zr * zr) + longint'(zi * zi);
			if (ovf || msq > limit_sq) begin
				r.escaped = 1'b1;
				r.iter_count = i[ITER_WIDTH-1:0];
				r.stripe_avg = (i != 0) ? AW'(total / i) : '0;
				return r;
			end
			nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
			ni = ((zr * zi) >>> (FRAC - 1)) + ci;
			zr = clamp_coord(nr, ovf);
			zi = clamp_coord(ni, ovf);
			mag = root_floor(longint'(zr * zr) + longint'(zi * zi));
			aim = (zi < 0) ? -zi : zi;
			if (mag != 0)
				total += (aim << (AW - 1)) / mag;
		end
		r.escaped = 1'b0;
		r.iter_count = limit_setting;
		r.stripe_avg = '0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// receiver: random stalls, or a held-off stretch
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		out_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 13);
	end

	always @(posedge clk) begin
		stripe_result_t w;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (escaped)
				escapes_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				w = pending_results.pop_front();
				if (escaped !== w.escaped)
					report_mismatch("escaped", escaped, w.escaped);
				if (iter_count !== w.iter_count)
					report_mismatch("iter_count", iter_count, w.iter_count);
				if (stripe_avg !== w.stripe_avg)
					report_mismatch("stripe_avg", stripe_avg, w.stripe_avg);
			end
		end
	end

	task automatic send_point(logic signed [CW-1:0] re, logic signed [CW-1:0] im);
		int gap = 0;
		while (!quiet && $urandom_range(99) < 13)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		c_re <= re;
		c_im <= im;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_point(re, im));
		points_sent++;
	endtask

	task automatic drain_and_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [APB_ADDR_WIDTH-1:0] addr, logic [APB_DATA_WIDTH-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MAX_ITER)
			limit_setting = data[ITER_WIDTH-1:0];
		else
			bailout_setting = data[BAIL_WIDTH-1:0];
	endtask

	task automatic set_config(int limit, int bail);
		drain_and_idle();
		write_reg(ADDR_MAX_ITER, limit);
		write_reg(ADDR_BAILOUT, bail);
	endtask

	function automatic logic signed [CW-1:0] near_set();
		// roughly +/-2.5 around the origin
		return CW'(int'($urandom_range(0, 1342177280)) - 671088640);
	endfunction

	task automatic test_directed();
		// reset limit: origin never escapes, all terms zero
		send_point(0, 0);
		set_config(40, 63);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point(0, 32'sh7FFF_FFFF);
		send_point(-2 * ONE, 0);
		send_point(0, ONE);
		send_point(-ONE, 0);
		send_point(2 * ONE, 0);
		send_point(ONE / 4, ONE / 2);
		send_point(-3 * ONE / 4, ONE / 10);
		send_point(ONE / 3, -ONE / 3);
		set_config(40, 4);
		send_point(2 * ONE, 0);
		send_point(ONE, ONE);
		send_point(-ONE, ONE / 3);
		send_point(-ONE, -1);
	endtask

	task automatic test_limit_extremes();
		set_config(0, 63);
		send_point(0, 0);
		send_point(3 * ONE, -ONE);
		set_config(1, 0);
		send_point(0, 0);
		send_point(ONE, 0);
		set_config(2, 0);
		send_point(1, 0);
		send_point(0, 0);
		set_config(1023, 63);
		send_point(ONE / 4, 0);
		send_point(7 * ONE, 7 * ONE);
		send_point(-ONE, ONE);
	endtask

	task automatic test_random();
		int n;
		for (int phase = 0; phase < 12; phase++) begin
			set_config($urandom_range(1, 32), $urandom_range(0, 63));
			quiet = (phase == 5);
			n = 30;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(99) < 80)
					send_point(near_set(), near_set());
				else
					send_point($urandom, $urandom);
			end
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		set_config(8, 16);
		hold_left <= 3000;
		@(posedge clk);
		for (int k = 0; k < 6; k++)
			send_point(near_set(), near_set());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limit_extremes();
		test_backpressure();
		test_random();
		drain_and_idle();
		$display("covered %0d points, %0d results, %0d escaped, limits 0..1023, bailout 0..63",
			points_sent, results_seen, escapes_seen);
		$display("with random stalls on both sides and one long output hold-off");
		if (error_count == 0)
			$display("mandelbrot_stripe_average_tb: done, clean");
		else
			$display("mandelbrot_stripe_average_tb: done, errors");
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("mandelbrot_stripe_average_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
